// ----- rtl/hit_sensor_qualifier_defines.svh -----
// Assertion macros shared by the hit sensor qualifier checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef HIT_SENSOR_QUALIFIER_DEFINES_SVH
`define HIT_SENSOR_QUALIFIER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define HSQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hit_sensor_qualifier: check failed");

// Check a property on every rising edge, reset included.
`define HSQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hit_sensor_qualifier: check failed");

`endif

// ----- rtl/hsq_pkg.sv -----
// Package for the hit sensor qualifier: constants, register and event codes,
// item structs. No dependencies.
`default_nettype none

package hsq_pkg;

  localparam int LINE_SLOTS = 3;
  localparam int NUM_LINES = 3;
  localparam int LINES_USED = (NUM_LINES < LINE_SLOTS) ? NUM_LINES : LINE_SLOTS;
  localparam int EV_SLOTS = 2 * LINE_SLOTS;
  localparam int SLOT_W = $clog2(EV_SLOTS);
  localparam int LINE_W = $clog2(LINE_SLOTS);

  localparam int DISCONNECT_TICKS_DEF = 10000;
  localparam int REMIND_ROUNDS_DEF = 30;

  localparam int CAL_W = 16;
  localparam int QUIET_W = CAL_W + 1;
  localparam logic [CAL_W-1:0] GAP_RESET = 16'd100;
  localparam logic [CAL_W-1:0] THR_RESET = 16'd4;
  localparam logic [LINE_SLOTS-1:0] INVERT_RESET = 3'b000;
  localparam logic [LINE_SLOTS-1:0] LEVEL_RESET = 3'b111;

  typedef enum logic [2:0] {
    CFG_GAP_FRONT,
    CFG_GAP_BACK,
    CFG_GAP_ENGINE,
    CFG_THR_FRONT,
    CFG_THR_BACK,
    CFG_THR_ENGINE,
    CFG_INVERT,
    CFG_ACTIVE_LEVEL
  } cfg_index_t;

  typedef enum logic [2:0] {
    EV_HIT        = 3'd0,
    EV_DISCONNECT = 3'd1,
    EV_REMIND     = 3'd2,
    EV_RECONNECT  = 3'd3,
    EV_BURST_END  = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic       level_front;
    logic       level_back;
    logic       level_engine;
    logic [2:0] blank_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  line_index;
    event_kind_t event_kind;
    logic [15:0] magnitude;
    logic        last_event;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/hit_sensor_qualifier.sv -----
// Hit sensor qualifier: takes one tick of raw line levels per input item and
// reports hits, burst ends and disconnect events. Uses hsq_pkg.
//
// An item is taken into an input register and handled once the event buffer
// has drained: all three lines update their counters in one pass and their
// events (at most two per line, six per item) load an event buffer. Events
// leave one per cycle while the output is not stalled, through the output
// register, lines in order front, back, engine, and the last event of an item
// carries last_event. Quiet ticks, which cause no event, stream at one item
// per clock; an item with events holds the next item in the input register
// while the event buffer drains. The configuration port is always ready;
// writes must be made while the block is idle; the block does not enforce it.
`default_nettype none

module hit_sensor_qualifier #(
  parameter int DISCONNECT_TICKS = hsq_pkg::DISCONNECT_TICKS_DEF,
  parameter int REMIND_ROUNDS = hsq_pkg::REMIND_ROUNDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hsq_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hsq_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire hsq_pkg::cfg_index_t cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import hsq_pkg::*;

  localparam int HW = (DISCONNECT_TICKS > 1) ? $clog2(DISCONNECT_TICKS + 1) : 1;
  localparam int RW = (REMIND_ROUNDS > 1) ? $clog2(REMIND_ROUNDS + 1) : 1;
  localparam logic [HW-1:0] DT_VAL = HW'(DISCONNECT_TICKS);
  localparam logic [RW-1:0] RR_VAL = RW'(REMIND_ROUNDS);

  // configuration
  logic [CAL_W-1:0]      gap [LINE_SLOTS];
  logic [CAL_W-1:0]      threshold [LINE_SLOTS];
  logic [LINE_SLOTS-1:0] invert_mask;
  logic [LINE_SLOTS-1:0] active_level_mask;

  // per line state
  logic [CAL_W-1:0]   active_count [LINE_SLOTS];
  logic [QUIET_W-1:0] quiet_count [LINE_SLOTS];
  logic               hit_latched [LINE_SLOTS];
  logic [HW-1:0]      high_count [LINE_SLOTS];
  logic [HW-1:0]      remind_low_count [LINE_SLOTS];
  logic [RW-1:0]      remind_high_count [LINE_SLOTS];
  logic               line_disconnected [LINE_SLOTS];

  logic [CAL_W-1:0]   active_count_next [LINE_SLOTS];
  logic [QUIET_W-1:0] quiet_count_next [LINE_SLOTS];
  logic               hit_latched_next [LINE_SLOTS];
  logic [HW-1:0]      high_count_next [LINE_SLOTS];
  logic [HW-1:0]      remind_low_count_next [LINE_SLOTS];
  logic [RW-1:0]      remind_high_count_next [LINE_SLOTS];
  logic               line_disconnected_next [LINE_SLOTS];

  // input register and event buffer
  in_item_t              in_r;
  logic                  in_r_valid;
  logic [EV_SLOTS-1:0]   pend;
  event_kind_t           ev_kind [EV_SLOTS];
  logic [CAL_W-1:0]      ev_mag [LINE_SLOTS];

  logic [EV_SLOTS-1:0]   pend_new;
  event_kind_t           ev_kind_new [EV_SLOTS];
  logic [CAL_W-1:0]      ev_mag_new [LINE_SLOTS];

  logic [LINE_SLOTS-1:0] lvl_vec;
  logic [SLOT_W-1:0]     sel_idx;
  logic [EV_SLOTS-1:0]   sel_mask;
  logic [EV_SLOTS-1:0]   pend_after;
  logic                  move;
  logic                  proc_go;

  logic                  cal_wr;
  logic                  cal_gap;
  logic [LINE_W-1:0]     cal_line;
  logic [CAL_W-1:0]      cal_val;

  assign lvl_vec = {in_r.level_engine, in_r.level_back, in_r.level_front};

  // pick the lowest pending event slot
  always_comb begin
    sel_idx = '0;
    for (int k = EV_SLOTS - 1; k >= 0; k--) begin
      if (pend[k]) begin
        sel_idx = SLOT_W'(k);
      end
    end
  end

  assign sel_mask   = EV_SLOTS'(1) << sel_idx;
  assign move       = (pend != '0) && (!out_valid || out_ready);
  assign pend_after = move ? (pend & ~sel_mask) : pend;
  assign proc_go    = in_r_valid && (pend_after == '0);
  assign in_ready   = !in_r_valid || proc_go;
  assign cfg_ready  = 1'b1;

  // one pass over all lines
  always_comb begin
    logic             lvl;
    logic             act;
    logic             disc_now;
    logic [CAL_W-1:0] act_inc;
    lvl      = 1'b0;
    act      = 1'b0;
    disc_now = 1'b0;
    act_inc  = '0;
    for (int i = 0; i < LINE_SLOTS; i++) begin
      active_count_next[i]      = active_count[i];
      quiet_count_next[i]       = quiet_count[i];
      hit_latched_next[i]       = hit_latched[i];
      high_count_next[i]        = high_count[i];
      remind_low_count_next[i]  = remind_low_count[i];
      remind_high_count_next[i] = remind_high_count[i];
      line_disconnected_next[i] = line_disconnected[i];
      pend_new[2*i]             = 1'b0;
      pend_new[2*i+1]           = 1'b0;
      ev_kind_new[2*i]          = EV_DISCONNECT;
      ev_kind_new[2*i+1]        = EV_HIT;
      ev_mag_new[i]             = '0;
      if (i < LINES_USED) begin
        lvl      = lvl_vec[i];
        disc_now = line_disconnected[i];
        if (lvl) begin
          if (high_count[i] == DT_VAL) begin
            if (!disc_now) begin
              disc_now      = 1'b1;
              pend_new[2*i] = 1'b1;
            end else if (remind_low_count[i] == DT_VAL) begin
              remind_low_count_next[i] = '0;
              if (remind_high_count[i] == RR_VAL) begin
                remind_high_count_next[i] = '0;
                pend_new[2*i]             = 1'b1;
                ev_kind_new[2*i]          = EV_REMIND;
              end else begin
                remind_high_count_next[i] = remind_high_count[i] + 1'b1;
              end
            end else begin
              remind_low_count_next[i] = remind_low_count[i] + 1'b1;
            end
          end else begin
            high_count_next[i] = high_count[i] + 1'b1;
          end
        end else if (high_count[i] == '0) begin
          if (disc_now) begin
            disc_now         = 1'b0;
            pend_new[2*i]    = 1'b1;
            ev_kind_new[2*i] = EV_RECONNECT;
          end
        end else begin
          high_count_next[i] = high_count[i] - 1'b1;
        end
        line_disconnected_next[i] = disc_now;

        // hit integration on connected, unblanked lines
        if (!in_r.blank_mask[i] && !disc_now) begin
          act = (lvl == active_level_mask[i]) ^ invert_mask[i];
          if (act) begin
            act_inc = (active_count[i] == '1) ? active_count[i] : active_count[i] + 1'b1;
            active_count_next[i] = act_inc;
            quiet_count_next[i]  = '0;
            if (!hit_latched[i] && act_inc == threshold[i]) begin
              hit_latched_next[i] = 1'b1;
              pend_new[2*i+1]     = 1'b1;
              ev_mag_new[i]       = act_inc;
            end
          end else if (quiet_count[i] < {1'b0, gap[i]}) begin
            quiet_count_next[i] = quiet_count[i] + 1'b1;
          end else if (quiet_count[i] == {1'b0, gap[i]}) begin
            quiet_count_next[i]  = quiet_count[i] + 1'b1;
            pend_new[2*i+1]      = 1'b1;
            ev_kind_new[2*i+1]   = EV_BURST_END;
            ev_mag_new[i]        = active_count[i];
            active_count_next[i] = '0;
            hit_latched_next[i]  = 1'b0;
          end
        end
      end
    end
  end

  // decode calibration writes
  always_comb begin
    cal_wr   = 1'b0;
    cal_gap  = 1'b0;
    cal_line = '0;
    case (cfg_index)
      CFG_GAP_FRONT: begin
        cal_wr  = 1'b1;
        cal_gap = 1'b1;
      end
      CFG_GAP_BACK: begin
        cal_wr   = 1'b1;
        cal_gap  = 1'b1;
        cal_line = LINE_W'(1);
      end
      CFG_GAP_ENGINE: begin
        cal_wr   = 1'b1;
        cal_gap  = 1'b1;
        cal_line = LINE_W'(2);
      end
      CFG_THR_FRONT: begin
        cal_wr = 1'b1;
      end
      CFG_THR_BACK: begin
        cal_wr   = 1'b1;
        cal_line = LINE_W'(1);
      end
      CFG_THR_ENGINE: begin
        cal_wr   = 1'b1;
        cal_line = LINE_W'(2);
      end
      default: begin
      end
    endcase
  end

  // zero is stored as one
  assign cal_val = (cfg_data == '0) ? CAL_W'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_r_valid        <= 1'b0;
      out_valid         <= 1'b0;
      pend              <= '0;
      invert_mask       <= INVERT_RESET;
      active_level_mask <= LEVEL_RESET;
      for (int i = 0; i < LINE_SLOTS; i++) begin
        gap[i]               <= GAP_RESET;
        threshold[i]         <= THR_RESET;
        active_count[i]      <= '0;
        quiet_count[i]       <= '0;
        hit_latched[i]       <= 1'b1;
        high_count[i]        <= '0;
        remind_low_count[i]  <= '0;
        remind_high_count[i] <= '0;
        line_disconnected[i] <= 1'b0;
      end
    end else begin
      in_r_valid <= (in_valid && in_ready) || (in_r_valid && !proc_go);

      if (proc_go) begin
        pend <= pend_new;
        for (int i = 0; i < LINE_SLOTS; i++) begin
          active_count[i]      <= active_count_next[i];
          quiet_count[i]       <= quiet_count_next[i];
          hit_latched[i]       <= hit_latched_next[i];
          high_count[i]        <= high_count_next[i];
          remind_low_count[i]  <= remind_low_count_next[i];
          remind_high_count[i] <= remind_high_count_next[i];
          line_disconnected[i] <= line_disconnected_next[i];
        end
      end else begin
        pend <= pend_after;
      end

      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        if (cal_wr) begin
          if (cal_gap) begin
            gap[cal_line] <= cal_val;
          end else begin
            threshold[cal_line] <= cal_val;
          end
          active_count[cal_line] <= '0;
          hit_latched[cal_line]  <= 1'b0;
        end
        if (cfg_index == CFG_INVERT) begin
          // lock every line whose sense flips
          for (int i = 0; i < LINE_SLOTS; i++) begin
            if (cfg_data[i] != invert_mask[i]) begin
              hit_latched[i] <= 1'b1;
            end
          end
          invert_mask <= cfg_data[LINE_SLOTS-1:0];
        end
        if (cfg_index == CFG_ACTIVE_LEVEL) begin
          active_level_mask <= cfg_data[LINE_SLOTS-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
    if (proc_go) begin
      for (int k = 0; k < EV_SLOTS; k++) begin
        ev_kind[k] <= ev_kind_new[k];
      end
      for (int i = 0; i < LINE_SLOTS; i++) begin
        ev_mag[i] <= ev_mag_new[i];
      end
    end
    if (move) begin
      out_item.line_index <= 2'(sel_idx[SLOT_W-1:1]);
      out_item.event_kind <= ev_kind[sel_idx];
      out_item.magnitude  <= sel_idx[0] ? ev_mag[sel_idx[SLOT_W-1:1]] : '0;
      out_item.last_event <= (pend_after == '0);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hsq_checker.sv -----
// Port-level checker for the hit sensor qualifier, bound to the top level.
// Uses hsq_pkg and the macros in hit_sensor_qualifier_defines.svh.
`default_nettype none

`include "hit_sensor_qualifier_defines.svh"

module hsq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hsq_pkg::out_item_t out_item
);
  import hsq_pkg::*;

  // a stalled result holds
  `HSQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item))

  // only real lines report
  `HSQ_ASSERT(a_line_range, out_valid |-> out_item.line_index < 2'd3)

  // disconnect watch events carry no count
  `HSQ_ASSERT(a_watch_mag, out_valid && (out_item.event_kind == EV_DISCONNECT || out_item.event_kind == EV_REMIND || out_item.event_kind == EV_RECONNECT) |-> out_item.magnitude == 16'd0)

  // a hit needs at least one active tick
  `HSQ_ASSERT(a_hit_mag, out_valid && out_item.event_kind == EV_HIT |-> out_item.magnitude != 16'd0)

  // nothing is shown right after reset
  `HSQ_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid)

endmodule

bind hit_sensor_qualifier hsq_checker u_hsq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ----- verif/tb_hit_sensor_qualifier.sv -----
// Self-checking bench for hit_sensor_qualifier: drives sample ticks and
// register writes, predicts every event and compares it field by field.
// Depends on hsq_pkg and the hit_sensor_qualifier RTL.
module tb_hit_sensor_qualifier;
  import hsq_pkg::*;

  localparam int SETTLE = 8;

  typedef struct {
    in_item_t tick;
    int       pause;
    bit       hold;
  } pending_tick_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_GAP_FRONT;
  logic [15:0] cfg_data = '0;

  hit_sensor_qualifier dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted copy of the block's registers and per-line state
  logic [15:0] gap_set [LINE_SLOTS];
  logic [15:0] thr_set [LINE_SLOTS];
  logic [2:0]  inv_set;
  logic [2:0]  level_set;
  logic [15:0] burst_len [LINE_SLOTS];
  logic [16:0] quiet_len [LINE_SLOTS];
  bit          hit_lock [LINE_SLOTS];
  logic [13:0] high_len [LINE_SLOTS];
  logic [13:0] remind_lo [LINE_SLOTS];
  logic [4:0]  remind_hi [LINE_SLOTS];
  bit          unplugged [LINE_SLOTS];

  pending_tick_t tick_q[$];
  out_item_t     due_events[$];
  pending_tick_t drv_cur;
  bit            drv_loaded = 1'b0;
  bit            drained = 1'b1;
  int            tx_max = 13;
  int            rx_max = 13;
  int            rx_wait = 0;
  int            ticks_taken = 0;
  int            writes_done = 0;
  int            mismatches = 0;
  int            kind_seen [5] = '{0, 0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("hit_sensor_qualifier test failed");
    $finish;
  end

  function automatic out_item_t make_event(int ln, event_kind_t k, logic [15:0] mag);
    out_item_t e;
    e.line_index = 2'(ln);
    e.event_kind = k;
    e.magnitude = mag;
    e.last_event = 1'b0;
    return e;
  endfunction

  // advance every line by one tick and queue the events it causes
  function automatic void qualify_tick(in_item_t it);
    logic [2:0] lv;
    bit         act;
    out_item_t  ev[$];
    out_item_t  e;
    lv = {it.level_engine, it.level_back, it.level_front};
    for (int i = 0; i < LINES_USED; i++) begin
      if (lv[i]) begin
        high_len[i]++;
        if (high_len[i] > DISCONNECT_TICKS_DEF) begin
          high_len[i] = 14'(DISCONNECT_TICKS_DEF);
          if (!unplugged[i]) begin
            unplugged[i] = 1'b1;
            ev.push_back(make_event(i, EV_DISCONNECT, 16'd0));
          end else begin
            remind_lo[i]++;
            if (remind_lo[i] > DISCONNECT_TICKS_DEF) begin
              remind_lo[i] = '0;
              remind_hi[i]++;
              if (remind_hi[i] > REMIND_ROUNDS_DEF) begin
                remind_hi[i] = '0;
                ev.push_back(make_event(i, EV_REMIND, 16'd0));
              end
            end
          end
        end
      end else if (high_len[i] == 0) begin
        if (unplugged[i]) begin
          unplugged[i] = 1'b0;
          ev.push_back(make_event(i, EV_RECONNECT, 16'd0));
        end
      end else begin
        high_len[i]--;
      end

      if (it.blank_mask[i] || unplugged[i]) continue;

      act = (lv[i] == level_set[i]) ^ inv_set[i];
      if (act) begin
        if (burst_len[i] != 16'hFFFF) burst_len[i]++;
        quiet_len[i] = '0;
        if (!hit_lock[i] && burst_len[i] == thr_set[i]) begin
          hit_lock[i] = 1'b1;
          ev.push_back(make_event(i, EV_HIT, burst_len[i]));
        end
      end else if (quiet_len[i] < gap_set[i]) begin
        quiet_len[i]++;
      end else if (quiet_len[i] == gap_set[i]) begin
        quiet_len[i]++;
        ev.push_back(make_event(i, EV_BURST_END, burst_len[i]));
        burst_len[i] = '0;
        hit_lock[i] = 1'b0;
      end
    end
    foreach (ev[k]) begin
      e = ev[k];
      e.last_event = (k == ev.size() - 1);
      due_events.push_back(e);
    end
  endfunction

  function automatic void apply_setting(cfg_index_t idx, logic [15:0] d);
    int          ln;
    logic [15:0] v;
    v = (d == 16'd0) ? 16'd1 : d;
    case (idx)
      CFG_GAP_FRONT, CFG_GAP_BACK, CFG_GAP_ENGINE: begin
        ln = int'(idx) - int'(CFG_GAP_FRONT);
        gap_set[ln] = v;
        burst_len[ln] = '0;
        hit_lock[ln] = 1'b0;
      end
      CFG_THR_FRONT, CFG_THR_BACK, CFG_THR_ENGINE: begin
        ln = int'(idx) - int'(CFG_THR_FRONT);
        thr_set[ln] = v;
        burst_len[ln] = '0;
        hit_lock[ln] = 1'b0;
      end
      CFG_INVERT: begin
        // a line whose sense flips stays locked until its next burst end
        for (int i = 0; i < LINE_SLOTS; i++)
          if (d[i] != inv_set[i]) hit_lock[i] = 1'b1;
        inv_set = d[2:0];
      end
      CFG_ACTIVE_LEVEL: begin
        level_set = d[2:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_item_t mk_tick(logic f, logic b, logic e, logic [2:0] blank);
    in_item_t t;
    t.level_front = f;
    t.level_back = b;
    t.level_engine = e;
    t.blank_mask = blank;
    return t;
  endfunction

  function automatic void push_tick(in_item_t t, int pause, bit hold);
    pending_tick_t p;
    p.tick = t;
    p.pause = pause;
    p.hold = hold;
    tick_q.push_back(p);
  endfunction

  task automatic wait_idle();
    while (tick_q.size() != 0 || drv_loaded || in_valid || due_events.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_setting(cfg_index_t idx, logic [15:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, d);
    writes_done++;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // bursts of active and quiet runs per line, with some noise and blanking
  task automatic queue_random_ticks(int count, int max_pause);
    bit         run_act [LINE_SLOTS];
    int         run_left [LINE_SLOTS];
    logic [2:0] lv;
    logic [2:0] blank;
    bit         a;
    for (int i = 0; i < LINE_SLOTS; i++) begin
      run_act[i] = 1'($urandom_range(0, 1));
      run_left[i] = $urandom_range(1, 6);
    end
    repeat (count) begin
      for (int i = 0; i < LINE_SLOTS; i++) begin
        if (run_left[i] == 0) begin
          run_act[i] = !run_act[i];
          run_left[i] = $urandom_range(1, 7);
        end
        run_left[i]--;
        a = run_act[i] ^ ($urandom_range(0, 9) == 0);
        lv[i] = (a ^ inv_set[i]) ? level_set[i] : ~level_set[i];
      end
      blank = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
      push_tick(mk_tick(lv[0], lv[1], lv[2], blank),
                ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_pause),
                $urandom_range(0, 29) == 0);
    end
  endtask

  // driver: present one tick at a time after its pause
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        qualify_tick(in_item);
        ticks_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (!drv_loaded && tick_q.size() != 0) begin
          drv_cur = tick_q.pop_front();
          drv_loaded = 1'b1;
        end
        if (drv_loaded) begin
          if (drv_cur.pause != 0) begin
            drv_cur.pause--;
          end else if (!drv_cur.hold || (drained && due_events.size() == 0)) begin
            in_item <= drv_cur.tick;
            next_valid = 1'b1;
            drv_loaded = 1'b0;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(negedge clk) drained = (due_events.size() == 0);

  // monitor: stall at random, check each event against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    logic      next_ready;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      next_ready = out_ready;
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected event: line %0d kind %0d mag %0d last %0b",
                     out_item.line_index, out_item.event_kind, out_item.magnitude,
                     out_item.last_event);
        end else begin
          want = due_events.pop_front();
          kind_seen[int'(want.event_kind)]++;
          if (out_item.line_index !== want.line_index ||
              out_item.event_kind !== want.event_kind ||
              out_item.magnitude !== want.magnitude ||
              out_item.last_event !== want.last_event) begin
            mismatches++;
            if (mismatches <= 10)
              $display("event mismatch: expected line %0d kind %0d mag %0d last %0b, %s",
                       want.line_index, want.event_kind, want.magnitude, want.last_event,
                       $sformatf("got line %0d kind %0d mag %0d last %0b",
                                 out_item.line_index, out_item.event_kind,
                                 out_item.magnitude, out_item.last_event));
          end
        end
        rx_wait = $urandom_range(0, rx_max);
      end else if (!out_ready && rx_wait != 0) begin
        rx_wait--;
      end
      next_ready = (rx_wait == 0);
      out_ready <= next_ready;
    end
  end

  initial begin
    int  p;
    int  w;
    bit  f;
    for (int i = 0; i < LINE_SLOTS; i++) begin
      gap_set[i] = GAP_RESET;
      thr_set[i] = THR_RESET;
      burst_len[i] = '0;
      quiet_len[i] = '0;
      hit_lock[i] = 1'b1;
      high_len[i] = '0;
      remind_lo[i] = '0;
      remind_hi[i] = '0;
      unplugged[i] = 1'b0;
    end
    inv_set = INVERT_RESET;
    level_set = LEVEL_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // latched out of reset: active ticks count but give no hit
    push_tick(mk_tick(1, 1, 1, 3'd0), $urandom_range(0, 13), 0);
    push_tick(mk_tick(1, 1, 1, 3'd0), $urandom_range(0, 13), 0);
    push_tick(mk_tick(1, 1, 1, 3'd7), $urandom_range(0, 13), 0);
    push_tick(mk_tick(1, 1, 1, 3'd0), $urandom_range(0, 13), 0);
    push_tick(mk_tick(1, 1, 1, 3'd5), $urandom_range(0, 13), 0);
    push_tick(mk_tick(1, 1, 1, 3'd2), $urandom_range(0, 13), 0);
    wait_idle();

    // zero gap and threshold store one; largest gap on the back line
    write_setting(CFG_GAP_FRONT, 16'd0);
    write_setting(CFG_GAP_BACK, 16'hFFFF);
    write_setting(CFG_GAP_ENGINE, 16'd2);
    write_setting(CFG_THR_FRONT, 16'd0);
    write_setting(CFG_THR_BACK, 16'd2);
    write_setting(CFG_THR_ENGINE, 16'd3);
    repeat (3) push_tick(mk_tick(1, 1, 1, 3'd0), $urandom_range(0, 3), 0);
    repeat (4) push_tick(mk_tick(0, 0, 0, 3'd0), $urandom_range(0, 3), 0);
    // hold this tick until every earlier event is out
    push_tick(mk_tick(1, 0, 1, 3'b010), 0, 1);
    wait_idle();

    // gap dropped below the quiet count: no burst end until an active tick
    write_setting(CFG_GAP_BACK, 16'd1);
    repeat (3) push_tick(mk_tick(0, 0, 0, 3'd0), $urandom_range(0, 13), 0);
    push_tick(mk_tick(0, 1, 0, 3'd0), 0, 0);
    repeat (2) push_tick(mk_tick(0, 0, 0, 3'd0), 0, 0);
    wait_idle();

    // invert change locks the back line until its next burst end
    write_setting(CFG_INVERT, 16'd2);
    repeat (3) push_tick(mk_tick(0, 0, 0, 3'd0), $urandom_range(0, 2), 0);
    repeat (2) push_tick(mk_tick(0, 1, 0, 3'd0), $urandom_range(0, 2), 0);
    repeat (2) push_tick(mk_tick(0, 0, 0, 3'd0), 0, 0);
    wait_idle();

    for (p = 0; p < 5; p++) begin
      tx_max = (p == 1 || p == 2) ? 0 : 13;
      rx_max = (p == 1 || p == 3) ? 0 : 13;
      f = p[0];
      if (f) write_setting(CFG_INVERT, (p == 1) ? 16'd7 : 16'($urandom_range(0, 7)));
      for (int r = 0; r < LINE_SLOTS; r++) begin
        write_setting(cfg_index_t'(int'(CFG_GAP_FRONT) + r),
                      (p == 1) ? 16'd0 : 16'($urandom_range(1, 5)));
        write_setting(cfg_index_t'(int'(CFG_THR_FRONT) + r),
                      (p == 1) ? 16'd0 :
                      (p == 4 && r == 0) ? 16'($urandom) : 16'($urandom_range(1, 6)));
      end
      if (!f) write_setting(CFG_INVERT, 16'($urandom_range(0, 7)));
      write_setting(CFG_ACTIVE_LEVEL, (p == 1) ? 16'd0 : 16'($urandom_range(0, 7)));
      queue_random_ticks(57, tx_max);
      wait_idle();
    end

    while (tick_q.size() != 0 || drv_loaded || in_valid) @(negedge clk);
    for (w = 0; w < 5000 && due_events.size() != 0; w++) @(negedge clk);
    repeat (SETTLE * 4) @(negedge clk);
    if (due_events.size() != 0) begin
      $display("%0d predicted events never arrived", due_events.size());
      mismatches += due_events.size();
    end

    $display("Ran %0d ticks and %0d register writes; events: %0d hits, %0d burst ends,",
             ticks_taken, writes_done, kind_seen[int'(EV_HIT)], kind_seen[int'(EV_BURST_END)]);
    $display("%0d disconnects, %0d reminders, %0d reconnects; %0d mismatches",
             kind_seen[int'(EV_DISCONNECT)], kind_seen[int'(EV_REMIND)],
             kind_seen[int'(EV_RECONNECT)], mismatches);
    if (mismatches == 0) begin
      $display("hit_sensor_qualifier test passed");
    end else begin
      $display("hit_sensor_qualifier test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hsq_pkg.sv
rtl/hit_sensor_qualifier.sv
rtl/hsq_checker.sv
verif/tb_hit_sensor_qualifier.sv
